/* hdl/itp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared sizes, character codes, command and status types and the
// character classification functions of the infix-to-prefix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int EXPR_LEN    = 32;
  localparam int STACK_DEPTH = 32;
  localparam int TXT_AW      = $clog2(EXPR_LEN);
  localparam int TXT_CW      = $clog2(EXPR_LEN + 1);
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_PLUS   = 8'h2B;  // +
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // -
  localparam logic [7:0] CH_STAR   = 8'h2A;  // *
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // /
  localparam logic [7:0] CH_BAR    = 8'h7C;  // |
  localparam logic [7:0] CH_PCT    = 8'h25;  // %
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // $
  localparam logic [7:0] CH_CARET  = 8'h5E;  // ^
  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    CLS_OPERAND = 2'd0,
    CLS_RPAREN  = 2'd1,
    CLS_LPAREN  = 2'd2,
    CLS_OPER    = 2'd3
  } itp_class_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic txt_rd;
    logic stk_rd;
    logic emit_txt;
    logic emit_stk;
    logic push;
    logic pop;
    logic idx_dec;
    logic set_err;
    logic out_init;
    logic out_rd;
    logic out_adv;
    logic clear;
  } itp_cmd_t;

  typedef struct packed {
    logic       idx_zero;
    logic       sp_zero;
    itp_class_t ch_class;
    logic       top_rparen;
    logic       pop_ok;
    logic       last_item;
  } itp_sts_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_PLUS, CH_MINUS:                 p = 2'd1;
      CH_STAR, CH_SLASH, CH_BAR, CH_PCT: p = 2'd2;
      CH_CARET, CH_DOLLAR:               p = 2'd3;
      default:                           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic itp_class_t classify(input logic [7:0] c);
    itp_class_t k;
    if (is_operand(c)) begin
      k = CLS_OPERAND;
    end else if (c == CH_RPAREN) begin
      k = CLS_RPAREN;
    end else if (c == CH_LPAREN) begin
      k = CLS_LPAREN;
    end else begin
      k = CLS_OPER;
    end
    return k;
  endfunction

endpackage

/* hdl/itp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_in_if
// Input channel: one infix character per item with a last marker.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

/* hdl/itp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_out_if
// Result channel: one prefix character per item with last and error flags.
// ----------------------------------------------------------------------------
interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       out_last;
  logic       error;

  modport source (output valid, output out_symbol, output out_last, output error,
                  input ready);
  modport sink   (input valid, input out_symbol, input out_last, input error,
                  output ready);
endinterface

/* hdl/itp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_datapath
// Text, operator stack and result memories with their counters, the error
// flag and the precedence compare used by the controller.
// ----------------------------------------------------------------------------
module itp_datapath import itp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  itp_cmd_t   cmd,
  output itp_sts_t   sts,
  input  logic [7:0] in_symbol,
  output logic [7:0] out_symbol,
  output logic       out_last,
  output logic       out_error
);

  logic [7:0] text_mem [EXPR_LEN];
  logic [7:0] stk_mem  [STACK_DEPTH];
  logic [7:0] res_mem  [EXPR_LEN];

  logic [TXT_CW-1:0] text_count_r, text_count_nxt;
  logic [TXT_CW-1:0] idx_r, idx_nxt;
  logic [STK_CW-1:0] sp_r, sp_nxt;
  logic [TXT_CW-1:0] rc_r, rc_nxt;
  logic [TXT_CW-1:0] ocnt_r, ocnt_nxt;
  logic              err_r, err_nxt;

  logic [7:0] ch_r;     // text character under scan
  logic [7:0] top_r;    // stack entry just read
  logic [7:0] res_r;    // result character being presented

  logic              text_ok;
  logic              push_ok;
  logic              emit_ok;
  logic              emit;
  logic [7:0]        emit_data;
  logic [TXT_CW-1:0] idx_m1;
  logic [STK_CW-1:0] sp_m1;
  logic [TXT_CW-1:0] ocnt_m1;
  logic              special;
  logic              right_assoc;
  logic [1:0]        p_ch;
  logic [1:0]        p_top;

  assign text_ok   = text_count_r < TXT_CW'(EXPR_LEN);
  assign push_ok   = sp_r < STK_CW'(STACK_DEPTH);
  assign emit_ok   = rc_r < TXT_CW'(EXPR_LEN);
  assign emit      = cmd.emit_txt | cmd.emit_stk;
  assign emit_data = cmd.emit_stk ? top_r : ch_r;
  assign idx_m1    = idx_r - 1'b1;
  assign sp_m1     = sp_r - 1'b1;
  assign ocnt_m1   = ocnt_r - 1'b1;

  always_comb begin
    text_count_nxt = text_count_r;
    idx_nxt        = idx_r;
    sp_nxt         = sp_r;
    rc_nxt         = rc_r;
    ocnt_nxt       = ocnt_r;
    err_nxt        = err_r;
    if (cmd.load) begin
      if (text_ok) begin
        text_count_nxt = text_count_r + 1'b1;
      end else begin
        err_nxt = 1'b1;
      end
    end
    if (cmd.scan_init) begin
      idx_nxt = text_count_nxt;
      sp_nxt  = '0;
      rc_nxt  = '0;
    end
    if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end
    if (cmd.push) begin
      if (push_ok) begin
        sp_nxt = sp_r + 1'b1;
      end else begin
        err_nxt = 1'b1;
      end
    end
    if (cmd.pop) begin
      sp_nxt = sp_m1;
    end
    if (emit) begin
      if (emit_ok) begin
        rc_nxt = rc_r + 1'b1;
      end else begin
        err_nxt = 1'b1;
      end
    end
    if (cmd.set_err) begin
      err_nxt = 1'b1;
    end
    if (cmd.out_init) begin
      ocnt_nxt = rc_r;
    end
    if (cmd.out_adv) begin
      ocnt_nxt = ocnt_m1;
    end
    if (cmd.clear) begin
      text_count_nxt = '0;
      sp_nxt         = '0;
      rc_nxt         = '0;
      err_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_count_r <= '0;
      idx_r        <= '0;
      sp_r         <= '0;
      rc_r         <= '0;
      ocnt_r       <= '0;
      err_r        <= 1'b0;
    end else begin
      text_count_r <= text_count_nxt;
      idx_r        <= idx_nxt;
      sp_r         <= sp_nxt;
      rc_r         <= rc_nxt;
      ocnt_r       <= ocnt_nxt;
      err_r        <= err_nxt;
    end
  end

  // Text memory: written while loading, read from the end during the scan.
  always_ff @(posedge clk) begin
    if (cmd.load && text_ok) begin
      text_mem[text_count_r[TXT_AW-1:0]] <= in_symbol;
    end
    if (cmd.txt_rd) begin
      ch_r <= text_mem[idx_m1[TXT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) begin
      stk_mem[sp_r[STK_AW-1:0]] <= ch_r;
    end
    if (cmd.stk_rd) begin
      top_r <= stk_mem[sp_m1[STK_AW-1:0]];
    end
  end

  // The result memory holds the prefix form reversed; it is read back from
  // the top down.
  always_ff @(posedge clk) begin
    if (emit && emit_ok) begin
      res_mem[rc_r[TXT_AW-1:0]] <= emit_data;
    end
    if (cmd.out_rd) begin
      res_r <= res_mem[ocnt_m1[TXT_AW-1:0]];
    end
  end

  assign p_ch        = prec_of(ch_r);
  assign p_top       = prec_of(top_r);
  assign right_assoc = (ch_r == CH_CARET) || (ch_r == CH_DOLLAR);
  assign special     = err_r || (rc_r == '0);

  always_comb begin
    sts.idx_zero   = (idx_r == '0);
    sts.sp_zero    = (sp_r == '0);
    sts.ch_class   = classify(ch_r);
    sts.top_rparen = (top_r == CH_RPAREN);
    sts.pop_ok     = (p_top > p_ch) || (right_assoc && (p_top == p_ch));
    sts.last_item  = special || (ocnt_r == TXT_CW'(1));
  end

  assign out_symbol = special ? CH_NUL : res_r;
  assign out_last   = sts.last_item;
  assign out_error  = err_r;

endmodule

/* hdl/itp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer for loading, the right-to-left shunting-yard scan, the final
// stack drain and the read-out of the prefix form.
// ----------------------------------------------------------------------------
module itp_ctrl import itp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  itp_sts_t sts,
  output itp_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_LOAD   = 11'b000_0000_0001,
    S_TXT_RD = 11'b000_0000_0010,
    S_TXT    = 11'b000_0000_0100,
    S_LP_RD  = 11'b000_0000_1000,
    S_LP     = 11'b000_0001_0000,
    S_OP_RD  = 11'b000_0010_0000,
    S_OP     = 11'b000_0100_0000,
    S_DR_RD  = 11'b000_1000_0000,
    S_DR     = 11'b001_0000_0000,
    S_OUT_RD = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } itp_state_t;

  itp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_TXT_RD;
          end
        end
      end
      S_TXT_RD: begin
        if (sts.idx_zero) begin
          state_nxt = S_DR_RD;
        end else begin
          cmd.txt_rd = 1'b1;
          state_nxt  = S_TXT;
        end
      end
      S_TXT: begin
        case (sts.ch_class)
          CLS_OPERAND: begin
            cmd.emit_txt = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_nxt    = S_TXT_RD;
          end
          CLS_RPAREN: begin
            cmd.push    = 1'b1;
            cmd.idx_dec = 1'b1;
            state_nxt   = S_TXT_RD;
          end
          CLS_LPAREN: begin
            state_nxt = S_LP_RD;
          end
          default: begin
            state_nxt = S_OP_RD;
          end
        endcase
      end
      S_LP_RD: begin
        // An opening parenthesis with nothing left to match is an error.
        if (sts.sp_zero) begin
          cmd.set_err = 1'b1;
          cmd.idx_dec = 1'b1;
          state_nxt   = S_TXT_RD;
        end else begin
          cmd.stk_rd = 1'b1;
          state_nxt  = S_LP;
        end
      end
      S_LP: begin
        cmd.pop = 1'b1;
        if (sts.top_rparen) begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_TXT_RD;
        end else begin
          cmd.emit_stk = 1'b1;
          state_nxt    = S_LP_RD;
        end
      end
      S_OP_RD: begin
        if (sts.sp_zero) begin
          cmd.push    = 1'b1;
          cmd.idx_dec = 1'b1;
          state_nxt   = S_TXT_RD;
        end else begin
          cmd.stk_rd = 1'b1;
          state_nxt  = S_OP;
        end
      end
      S_OP: begin
        if (sts.pop_ok) begin
          cmd.emit_stk = 1'b1;
          cmd.pop      = 1'b1;
          state_nxt    = S_OP_RD;
        end else begin
          cmd.push    = 1'b1;
          cmd.idx_dec = 1'b1;
          state_nxt   = S_TXT_RD;
        end
      end
      S_DR_RD: begin
        if (sts.sp_zero) begin
          cmd.out_init = 1'b1;
          state_nxt    = S_OUT_RD;
        end else begin
          cmd.stk_rd = 1'b1;
          state_nxt  = S_DR;
        end
      end
      S_DR: begin
        // A closing parenthesis left over at the end is unmatched.
        cmd.pop = 1'b1;
        if (sts.top_rparen) begin
          cmd.set_err = 1'b1;
        end else begin
          cmd.emit_stk = 1'b1;
        end
        state_nxt = S_DR_RD;
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last_item) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            cmd.out_adv = 1'b1;
            state_nxt   = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

/* hdl/infix_to_prefix_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_prefix_converter
// Converts an infix expression, one character per item, into its prefix form.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle and stored, up to EXPR_LEN of them;
// longer input sets the error flag. The item marked last starts the
// conversion, during which no input is taken: the stored text is scanned from
// right to left with an operator stack held in a single-port-per-side memory,
// so each character is first read from memory and then decided on, and each
// stack pop first reads the stack top and then acts on it. An operator also
// checks for an empty stack, or reads and compares the stack top, before each
// push it finally makes. The prefix form is then read out of the result
// memory: each item is read, then held on offer until the sink takes it,
// and only then is the next item read. An error gives a single item with
// symbol 0, last and error set; an empty result gives a single item with
// symbol 0 and last set. The block then waits for the next expression.
module infix_to_prefix_converter import itp_pkg::*; (
  input logic clk,
  input logic rst_n,
  itp_in_if.sink    in_ch,
  itp_out_if.source out_ch
);

  itp_cmd_t cmd;
  itp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_symbol  (in_ch.symbol),
    .out_symbol (out_ch.out_symbol),
    .out_last   (out_ch.out_last),
    .out_error  (out_ch.error)
  );

  // Input is never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is valid");

  // An error result is a single, final, empty item.
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error) |-> (out_ch.out_last && out_ch.out_symbol == CH_NUL))
    else $error("error result is not a single empty final item");

  a_stack_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.pop))
    else $error("push and pop in the same cycle");

  // After the final item is taken the block is ready for a new expression.
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.out_last) |=> in_ch.ready)
    else $error("not ready for input after the final result");

endmodule
